### rtl/core/packet_header_parse_and_decrypt_unit_assert.svh
// assertion macros shared by the packet header parse and decrypt rtl
`ifndef PACKET_HEADER_PARSE_AND_DECRYPT_UNIT_ASSERT_SVH
`define PACKET_HEADER_PARSE_AND_DECRYPT_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PHPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PHPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/phpd_pkg.sv
// types, constants and keystream tables of the packet header parse and decrypt unit
package phpd_pkg;

  localparam int unsigned SeedMul    = 33721;
  localparam int unsigned SeedMod    = 65537;
  localparam int unsigned KsMod      = 251;
  localparam int unsigned KsMul      = 97;
  localparam int unsigned PlainLimit = 2;
  localparam int unsigned HdrBytes   = 6;
  localparam int unsigned HdrPosW    = 3;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  op_lo;
    logic [7:0]  key_value;
    logic [23:0] payload_length;
    logic        last;
  } phpd_entry_t;

  typedef logic [255:0][7:0] ks_tab_t;

  // one keystream step: c * 97 mod 251
  function automatic ks_tab_t build_step_tab();
    ks_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 8'((i * KsMul) % KsMod);
    end
    return tab;
  endfunction

  // seed per key, zero for plain keys
  function automatic ks_tab_t build_seed_tab();
    ks_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      if (i < PlainLimit) begin
        tab[i] = 8'd0;
      end else begin
        tab[i] = 8'((((i - PlainLimit) * SeedMul) % SeedMod) % KsMod);
      end
    end
    return tab;
  endfunction

  // first keystream step after the seed, per key
  function automatic ks_tab_t build_first_tab();
    ks_tab_t tab;
    ks_tab_t seed;
    seed = build_seed_tab();
    for (int i = 0; i < 256; i++) begin
      tab[i] = 8'((int'(seed[i]) * KsMul) % KsMod);
    end
    return tab;
  endfunction

  localparam ks_tab_t StepTab  = build_step_tab();
  localparam ks_tab_t SeedTab  = build_seed_tab();
  localparam ks_tab_t FirstTab = build_first_tab();

endpackage

### rtl/core/phpd_in_if.sv
// byte stream channel into the unit
interface phpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

### rtl/core/phpd_out_if.sv
// result channel out of the unit
interface phpd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] opcode;
  logic [7:0]  payload_byte;
  logic [23:0] payload_length;
  logic [7:0]  key_value;
  logic        last;

  modport source (
    output valid, output kind, output opcode, output payload_byte,
    output payload_length, output key_value, output last, input ready
  );
  modport sink (
    input valid, input kind, input opcode, input payload_byte,
    input payload_length, input key_value, input last, output ready
  );
endinterface

### rtl/core/phpd_front.sv
// front end: collects header bytes, counts payload and classifies each byte
module phpd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  phpd_in_if.sink              in_i,
  output logic                 push_valid_o,
  output phpd_pkg::phpd_entry_t push_entry_o,
  input  logic                 queue_full_i
);
  import phpd_pkg::*;

  logic [HdrPosW-1:0] hdr_pos_q, hdr_pos_d;
  logic [39:0]        hdr_q, hdr_d;
  logic [23:0]        remain_q, remain_d;
  logic               accept;
  logic               in_payload;
  logic               hdr_final;

  assign in_payload = (remain_q != 24'd0);
  assign hdr_final  = !in_payload && (hdr_pos_q == HdrPosW'(HdrBytes - 1));

  // header bytes before the last one need no queue slot
  assign in_i.ready = !queue_full_i || (!in_payload && !hdr_final);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    hdr_pos_d = hdr_pos_q;
    hdr_d     = hdr_q;
    remain_d  = remain_q;
    if (accept) begin
      if (in_payload) begin
        remain_d = remain_q - 24'd1;
      end else if (hdr_final) begin
        remain_d  = hdr_q[23:0];
        hdr_pos_d = '0;
      end else begin
        for (int i = 0; i < HdrBytes - 1; i++) begin
          if (hdr_pos_q == HdrPosW'(i)) begin
            hdr_d[8*i +: 8] = in_i.data_byte;
          end
        end
        hdr_pos_d = hdr_pos_q + HdrPosW'(1);
      end
    end
  end

  always_comb begin
    push_valid_o                = accept && (in_payload || hdr_final);
    push_entry_o.data_byte      = in_i.data_byte;
    push_entry_o.key_value      = hdr_q[31:24];
    push_entry_o.payload_length = hdr_q[23:0];
    if (in_payload) begin
      push_entry_o.kind  = KIND_PAYLOAD;
      push_entry_o.op_lo = 8'd0;
      push_entry_o.last  = (remain_q == 24'd1);
    end else begin
      push_entry_o.kind  = KIND_HEADER;
      push_entry_o.op_lo = hdr_q[39:32];
      push_entry_o.last  = (hdr_q[23:0] == 24'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q <= '0;
      hdr_q     <= '0;
      remain_q  <= '0;
    end else begin
      hdr_pos_q <= hdr_pos_d;
      hdr_q     <= hdr_d;
      remain_q  <= remain_d;
    end
  end

endmodule

### rtl/core/phpd_queue.sv
// short queue between the front end and the decrypt back end
`include "packet_header_parse_and_decrypt_unit_assert.svh"

module phpd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  phpd_pkg::phpd_entry_t push_entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  entry_valid_o,
  output phpd_pkg::phpd_entry_t entry_o
);
  import phpd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  phpd_entry_t     slots_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o        = (count_q == CntW'(QueueDepth));
  assign entry_valid_o = (count_q != '0);
  assign entry_o       = slots_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `PHPD_ASSERT_IMPL(a_no_overflow, push_i && !pop_i, !full_o, "push into a full queue")
  `PHPD_ASSERT_IMPL(a_no_underflow, pop_i, entry_valid_o, "pop from an empty queue")
  `PHPD_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "count lost")

endmodule

### rtl/core/phpd_back.sv
// back end: keystream, opcode and payload decrypt, output register
`include "packet_header_parse_and_decrypt_unit_assert.svh"

module phpd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  entry_valid_i,
  input  phpd_pkg::phpd_entry_t entry_i,
  output logic                  pop_o,
  phpd_out_if.source            out_o
);
  import phpd_pkg::*;

  logic        out_valid_q;
  logic        cipher_q, cipher_d;
  logic [7:0]  ks_q, ks_d;
  logic [15:0] opcode_q, opcode_d;
  kind_e       kind_q;
  logic [7:0]  pbyte_q, pbyte_d;
  logic [23:0] length_q;
  logic [7:0]  key_q;
  logic        last_q;
  logic [7:0]  step;
  logic [7:0]  seed;
  logic [7:0]  first;
  logic        key_cipher;
  logic        hdr_pop;

  assign pop_o   = entry_valid_i && (!out_valid_q || out_o.ready);
  assign hdr_pop = pop_o && (entry_i.kind == KIND_HEADER);

  assign step       = StepTab[ks_q];
  assign seed       = SeedTab[entry_i.key_value];
  assign first      = FirstTab[entry_i.key_value];
  assign key_cipher = (entry_i.key_value >= 8'(PlainLimit));

  always_comb begin
    cipher_d = cipher_q;
    ks_d     = ks_q;
    opcode_d = opcode_q;
    pbyte_d  = entry_i.data_byte;
    if (entry_i.kind == KIND_HEADER) begin
      // plain keys map to a zero seed and step, so the xor is a no-op
      cipher_d = key_cipher;
      ks_d     = key_cipher ? first : 8'd0;
      opcode_d = {entry_i.data_byte, entry_i.op_lo} ^ {first, seed};
      pbyte_d  = 8'd0;
    end else if (cipher_q) begin
      ks_d    = step;
      pbyte_d = entry_i.data_byte ^ step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cipher_q    <= 1'b0;
      ks_q        <= '0;
      opcode_q    <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        cipher_q    <= cipher_d;
        ks_q        <= ks_d;
        opcode_q    <= opcode_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= entry_i.kind;
      pbyte_q  <= pbyte_d;
      length_q <= entry_i.payload_length;
      key_q    <= entry_i.key_value;
      last_q   <= entry_i.last;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = kind_q;
  assign out_o.opcode         = opcode_q;
  assign out_o.payload_byte   = pbyte_q;
  assign out_o.payload_length = length_q;
  assign out_o.key_value      = key_q;
  assign out_o.last           = last_q;

  `PHPD_ASSERT_IMPL(a_plain_ks_zero, !cipher_q, ks_q == 8'd0, "keystream nonzero while plain")
  `PHPD_ASSERT_IMPL(a_no_overwrite, out_valid_q && !out_o.ready, !pop_o, "result overwritten")
  `PHPD_ASSERT_NEXT(a_hdr_result, hdr_pop, out_valid_q && (kind_q == KIND_HEADER), "header lost")

endmodule

### rtl/core/packet_header_parse_and_decrypt_unit.sv
// a byte's result is registered in a queue slot, then in the output register
// throughput: one byte per cycle unless stalled; header bytes one to five give no result
// the keystream step is one table lookup per payload byte, held in the back end
// a two-entry queue and the output register let input and output stall on their own
// reset: asynchronous, active low; clears header, count, keystream and valid state
module packet_header_parse_and_decrypt_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  phpd_in_if.sink    in_i,
  phpd_out_if.source out_o
);
  import phpd_pkg::*;

  logic        push_valid;
  phpd_entry_t push_entry;
  logic        queue_full;
  logic        pop;
  logic        entry_valid;
  phpd_entry_t entry;

  phpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .queue_full_i (queue_full)
  );

  phpd_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_valid),
    .push_entry_i  (push_entry),
    .full_o        (queue_full),
    .pop_i         (pop),
    .entry_valid_o (entry_valid),
    .entry_o       (entry)
  );

  phpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (entry_valid),
    .entry_i       (entry),
    .pop_o         (pop),
    .out_o         (out_o)
  );

endmodule

### tb/packet_header_parse_and_decrypt_unit_test.sv
// testbench of the packet header parse and decrypt unit: byte stream in, checked results out
module packet_header_parse_and_decrypt_unit_test;
  import phpd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned MaxGap     = 11;
  localparam int unsigned DrainWait  = 20;

  typedef struct {
    logic [7:0] value;
    int unsigned gap;
    bit drain;
  } stream_byte_t;

  typedef struct {
    kind_e       kind;
    logic [15:0] opcode;
    logic [7:0]  payload_byte;
    logic [23:0] payload_length;
    logic [7:0]  key_value;
    logic        last;
  } parsed_result_t;

  logic clk;
  logic rst_n;

  phpd_in_if  in_ch ();
  phpd_out_if out_ch ();

  packet_header_parse_and_decrypt_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // predictor state
  logic [2:0]  hdr_pos;
  logic [39:0] hdr_bytes;
  logic [23:0] bytes_left;
  logic [7:0]  ks_value;
  logic        cipher_on;
  logic [15:0] cur_opcode;

  stream_byte_t   stream_bytes[$];
  parsed_result_t expected_results[$];

  int unsigned error_count;
  int unsigned bytes_taken;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned hold_left;
  int unsigned holds_done;
  int unsigned hold_points[2] = '{300, 1100};

  // driver bookkeeping
  bit          have_item;
  int unsigned send_wait;
  int unsigned rx_wait;

  task automatic report_mismatch(input string msg);
    $display("error: result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  function automatic void decrypt_byte(input logic [7:0] b);
    parsed_result_t r;
    logic [15:0]    op;
    logic [7:0]     key;
    int unsigned    seed;
    int unsigned    step;
    if (bytes_left != 0) begin
      r.payload_byte = b;
      if (cipher_on) begin
        ks_value = 8'((int'(ks_value) * KsMul) % KsMod);
        r.payload_byte = b ^ ks_value;
      end
      bytes_left = bytes_left - 24'd1;
      r.kind = KIND_PAYLOAD;
      r.opcode = cur_opcode;
      r.payload_length = hdr_bytes[23:0];
      r.key_value = hdr_bytes[31:24];
      r.last = (bytes_left == 0);
      expected_results.push_back(r);
    end else if (hdr_pos < 3'd5) begin
      hdr_bytes[8*hdr_pos +: 8] = b;
      hdr_pos = hdr_pos + 3'd1;
    end else begin
      op = {b, hdr_bytes[39:32]};
      key = hdr_bytes[31:24];
      if (key >= PlainLimit) begin
        seed = (((int'(key) - PlainLimit) * SeedMul) % SeedMod) % KsMod;
        step = (seed * KsMul) % KsMod;
        op = op ^ {step[7:0], seed[7:0]};
        ks_value = step[7:0];
        cipher_on = 1'b1;
      end else begin
        ks_value = 8'd0;
        cipher_on = 1'b0;
      end
      cur_opcode = op;
      bytes_left = hdr_bytes[23:0];
      hdr_pos = 3'd0;
      r.kind = KIND_HEADER;
      r.opcode = op;
      r.payload_byte = 8'd0;
      r.payload_length = hdr_bytes[23:0];
      r.key_value = key;
      r.last = (hdr_bytes[23:0] == 0);
      expected_results.push_back(r);
    end
  endfunction

  task automatic add_byte(input logic [7:0] value, input bit fast, input bit drain);
    stream_byte_t s;
    s.value = value;
    s.gap = fast ? 0 : $urandom_range(0, MaxGap);
    s.drain = drain;
    stream_bytes.push_back(s);
  endtask

  // header then payload_count random payload bytes; the count may stop short of size
  task automatic add_packet(input logic [23:0] size, input logic [7:0] key,
                            input logic [15:0] op, input int unsigned payload_count,
                            input bit fast, input bit drain);
    add_byte(size[7:0], fast, drain);
    add_byte(size[15:8], fast, 1'b0);
    add_byte(size[23:16], fast, 1'b0);
    add_byte(key, fast, 1'b0);
    add_byte(op[7:0], fast, 1'b0);
    add_byte(op[15:8], fast, 1'b0);
    for (int unsigned i = 0; i < payload_count; i++) begin
      add_byte(8'($urandom), fast, 1'b0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // receiver hold-off long enough to back up the unit into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && bytes_taken >= hold_points[holds_done]) begin
      hold_left <= HoldCycles;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin : drive_proc
    logic         next_valid;
    logic [7:0]   next_byte;
    stream_byte_t cur;
    next_valid = in_ch.valid;
    next_byte = in_ch.data_byte;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decrypt_byte(in_ch.data_byte);
        bytes_taken <= bytes_taken + 1;
        next_valid = 1'b0;
      end
      if (!next_valid && !have_item && stream_bytes.size() != 0) begin
        cur = stream_bytes.pop_front();
        have_item = 1'b1;
        send_wait = cur.gap;
      end
      if (!next_valid && have_item) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (!cur.drain || expected_results.size() == 0) begin
          next_valid = 1'b1;
          next_byte = cur.value;
          have_item = 1'b0;
        end
      end
    end
    in_ch.valid <= next_valid;
    in_ch.data_byte <= next_byte;
  end

  always @(posedge clk) begin : result_proc
    parsed_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_ch.kind != want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_ch.kind, want.kind));
          if (out_ch.opcode != want.opcode)
            report_mismatch($sformatf("opcode %h, want %h", out_ch.opcode, want.opcode));
          if (out_ch.payload_byte != want.payload_byte)
            report_mismatch($sformatf("payload_byte %h, want %h",
                                      out_ch.payload_byte, want.payload_byte));
          if (out_ch.payload_length != want.payload_length)
            report_mismatch($sformatf("payload_length %h, want %h",
                                      out_ch.payload_length, want.payload_length));
          if (out_ch.key_value != want.key_value)
            report_mismatch($sformatf("key_value %h, want %h",
                                      out_ch.key_value, want.key_value));
          if (out_ch.last != want.last)
            report_mismatch($sformatf("last %0d, want %0d", out_ch.last, want.last));
        end
        results_seen++;
        // alternate stretches of free flow and random stalls
        rx_wait = results_seen[6] ? 0 : $urandom_range(0, MaxGap);
      end
      if (rx_wait != 0) rx_wait--;
      out_ch.ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("packet_header_parse_and_decrypt_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus_proc
    int unsigned pkt_idx;
    int unsigned pick;
    logic [23:0] size;
    logic [7:0]  key;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    out_ch.ready = 1'b0;
    hdr_pos = 3'd0;
    hdr_bytes = 40'd0;
    bytes_left = 24'd0;
    ks_value = 8'd0;
    cipher_on = 1'b0;
    cur_opcode = 16'd0;
    have_item = 1'b0;
    send_wait = 0;
    rx_wait = 0;
    error_count = 0;
    bytes_taken = 0;
    results_seen = 0;
    cycle_count = 0;

    // empty payload with plain key, plain key one, key of two, top key with empty payload
    add_packet(24'd0, 8'd0, 16'h0000, 0, 1'b1, 1'b0);
    add_packet(24'd1, 8'd1, 16'hffff, 1, 1'b0, 1'b0);
    add_packet(24'd2, 8'd2, 16'h1234, 2, 1'b1, 1'b0);
    add_packet(24'd0, 8'hff, 16'hffff, 0, 1'b0, 1'b0);

    pkt_idx = 0;
    while (stream_bytes.size() < 1600) begin
      pick = $urandom_range(0, 15);
      if (pick < 2) size = 24'd0;
      else if (pick < 13) size = 24'($urandom_range(1, 24));
      else if (pick < 15) size = 24'($urandom_range(25, 200));
      else size = 24'($urandom_range(201, 400));
      key = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
      add_packet(size, key, 16'($urandom), 32'(size), $urandom_range(0, 3) == 0,
                 pkt_idx == 12 || pkt_idx == 60);
      pkt_idx++;
    end
    // huge size left open at the end of the stream
    add_packet(24'hffffff, 8'($urandom), 16'($urandom), 8, 1'b0, 1'b0);

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (stream_bytes.size() != 0 || have_item || in_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (error_count == 0) begin
      $display("packet_header_parse_and_decrypt_unit: match");
    end else begin
      $display("packet_header_parse_and_decrypt_unit: mismatch");
    end
    $finish;
  end

endmodule
